// File: src/minv_pkg.sv
// modular inverse: shared types, constants and sequencer codes
// no dependencies; imported by every other file of the block
`timescale 1ns / 1ps

package minv_pkg;

    localparam int OPERAND_WIDTH = 32;
    localparam int CNT_W = $clog2(OPERAND_WIDTH);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HEAD,
        ST_ALIGN,
        ST_DIV,
        ST_SWAP,
        ST_FIX,
        ST_NEG,
        ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_HEAD,
        OP_ALIGN,
        OP_DIV,
        OP_SWAP,
        OP_FIX,
        OP_NEG
    } op_t;

    typedef struct packed {
        op_t op;
    } ctrl_t;

    typedef struct packed {
        logic m_small;
        logic r1_zero;
        logic r0_one;
        logic can_shift;
        logic k_zero;
    } status_t;

endpackage

// File: src/minv_alu.sv
// modular inverse: shared subtract and compare unit
// depends on minv_pkg
`timescale 1ns / 1ps

module minv_alu
    import minv_pkg::*;
(
    input  logic [OPERAND_WIDTH-1:0] x,
    input  logic [OPERAND_WIDTH:0]   y,
    output logic [OPERAND_WIDTH-1:0] diff,
    output logic                     ge
);

    logic [OPERAND_WIDTH+1:0] full;

    // extra top bit is the borrow
    assign full = {2'b00, x} - {1'b0, y};
    assign ge   = ~full[OPERAND_WIDTH+1];
    assign diff = full[OPERAND_WIDTH-1:0];

endmodule

// File: src/minv_dpath.sv
// modular inverse: remainder, coefficient and shift registers around the shared unit
// depends on minv_pkg and minv_alu
`timescale 1ns / 1ps

module minv_dpath
    import minv_pkg::*;
(
    input  logic                     aclk,
    input  ctrl_t                    ctrl,
    input  logic [OPERAND_WIDTH-1:0] value,
    input  logic [OPERAND_WIDTH-1:0] modulus,
    output status_t                  status,
    output logic [OPERAND_WIDTH-1:0] inverse,
    output logic                     not_invertible
);

    localparam int W = OPERAND_WIDTH;

    logic [W-1:0]     r0_reg, r0_next, r1_reg, r1_next;
    logic [W-1:0]     c0_reg, c0_next, c1_reg, c1_next;
    logic [W-1:0]     d_reg, d_next, e_reg, e_next;
    logic [W-1:0]     m_reg, m_next;
    logic [W-1:0]     inv_reg, inv_next;
    logic [CNT_W-1:0] k_reg, k_next;
    logic             odd_reg, odd_next;
    logic             bad_reg, bad_next;

    logic [W-1:0]     alu_x;
    logic [W:0]       alu_y;
    logic [W-1:0]     alu_diff;
    logic             alu_ge;
    logic [W:0]       c_sum;

    minv_alu u_alu (
        .x    (alu_x),
        .y    (alu_y),
        .diff (alu_diff),
        .ge   (alu_ge)
    );

    // operand select for the shared unit
    always_comb begin
        case (ctrl.op)
            OP_ALIGN: begin
                alu_x = r0_reg;
                alu_y = {d_reg, 1'b0};
            end
            OP_FIX: begin
                alu_x = c0_reg;
                alu_y = {1'b0, m_reg};
            end
            OP_NEG: begin
                alu_x = m_reg;
                alu_y = {1'b0, c0_reg};
            end
            default: begin
                alu_x = r0_reg;
                alu_y = {1'b0, d_reg};
            end
        endcase
    end

    assign c_sum = {1'b0, c0_reg} + {1'b0, e_reg};

    assign status.m_small   = (m_reg[W-1:1] == '0);
    assign status.r1_zero   = (r1_reg == '0);
    assign status.r0_one    = (r0_reg == W'(1));
    assign status.can_shift = alu_ge & ~d_reg[W-1];
    assign status.k_zero    = (k_reg == '0);

    always_comb begin
        r0_next  = r0_reg;
        r1_next  = r1_reg;
        c0_next  = c0_reg;
        c1_next  = c1_reg;
        d_next   = d_reg;
        e_next   = e_reg;
        m_next   = m_reg;
        k_next   = k_reg;
        odd_next = odd_reg;
        inv_next = inv_reg;
        bad_next = bad_reg;
        case (ctrl.op)
            OP_LOAD: begin
                r0_next  = modulus;
                r1_next  = value;
                c0_next  = '0;
                c1_next  = W'(1);
                m_next   = modulus;
                odd_next = 1'b0;
            end
            OP_HEAD: begin
                d_next   = r1_reg;
                e_next   = c1_reg;
                k_next   = '0;
                inv_next = '0;
                bad_next = status.m_small | (status.r1_zero & ~status.r0_one);
            end
            OP_ALIGN: begin
                if (status.can_shift) begin
                    d_next = {d_reg[W-2:0], 1'b0};
                    e_next = {e_reg[W-2:0], 1'b0};
                    k_next = k_reg + CNT_W'(1);
                end
            end
            OP_DIV: begin
                if (alu_ge) begin
                    r0_next = alu_diff;
                    c0_next = c_sum[W-1:0];
                end
                if (!status.k_zero) begin
                    d_next = {1'b0, d_reg[W-1:1]};
                    e_next = {1'b0, e_reg[W-1:1]};
                    k_next = k_reg - CNT_W'(1);
                end
            end
            OP_SWAP: begin
                r0_next  = r1_reg;
                r1_next  = r0_reg;
                c0_next  = c1_reg;
                c1_next  = c0_reg;
                odd_next = ~odd_reg;
            end
            OP_FIX: begin
                if (alu_ge) begin
                    c0_next = alu_diff;
                end
            end
            OP_NEG: begin
                bad_next = 1'b0;
                // even step count means the coefficient is negative
                if (odd_reg || (c0_reg == '0)) begin
                    inv_next = c0_reg;
                end else begin
                    inv_next = alu_diff;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        r0_reg  <= r0_next;
        r1_reg  <= r1_next;
        c0_reg  <= c0_next;
        c1_reg  <= c1_next;
        d_reg   <= d_next;
        e_reg   <= e_next;
        m_reg   <= m_next;
        k_reg   <= k_next;
        odd_reg <= odd_next;
        inv_reg <= inv_next;
        bad_reg <= bad_next;
    end

    assign inverse        = inv_reg;
    assign not_invertible = bad_reg;

endmodule

// File: src/minv_fsm.sv
// modular inverse: sequencer that steps the shared unit through the euclid loop
// depends on minv_pkg
`timescale 1ns / 1ps

module minv_fsm
    import minv_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    input  logic    out_ready,
    input  status_t status,
    output ctrl_t   ctrl,
    output logic    in_ready,
    output logic    out_valid
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        ctrl.op    = OP_NONE;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    ctrl.op    = OP_LOAD;
                    state_next = ST_HEAD;
                end
            end
            ST_HEAD: begin
                ctrl.op = OP_HEAD;
                if (status.m_small) begin
                    state_next = ST_DONE;
                end else if (status.r1_zero) begin
                    state_next = status.r0_one ? ST_FIX : ST_DONE;
                end else begin
                    state_next = ST_ALIGN;
                end
            end
            ST_ALIGN: begin
                ctrl.op = OP_ALIGN;
                if (!status.can_shift) begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                ctrl.op = OP_DIV;
                if (status.k_zero) begin
                    state_next = ST_SWAP;
                end
            end
            ST_SWAP: begin
                ctrl.op    = OP_SWAP;
                state_next = ST_HEAD;
            end
            ST_FIX: begin
                ctrl.op    = OP_FIX;
                state_next = ST_NEG;
            end
            ST_NEG: begin
                ctrl.op    = OP_NEG;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                out_valid = 1'b1;
                if (out_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: src/modular_inverse_top.sv
// modular inverse: top level, stream ports, sequencer and datapath
// depends on minv_pkg, minv_fsm, minv_dpath (and minv_alu below it)
`timescale 1ns / 1ps
//
//  channel | dir | beat contents
//  --------+-----+--------------------------------------------------
//  s_      | in  | tdata[31:0] value, tdata[63:32] modulus
//  m_      | out | tdata[31:0] inverse, tuser[0] not_invertible
//
//  extended euclid, each quotient found by shift-and-subtract on one shared
//  subtract/compare unit; a quotient step runs head, align shifts, subtract steps
//  and swap, and a whole inverse adds accept, the last head, the sign fix-up
//  (fix, neg) and the output beat; flagged operands go from a head to the output beat
//  aresetn (synchronous, active low) returns the sequencer to idle
//  one beat in flight: s_tready is low from accept until the result beat is taken

module modular_inverse_top
    import minv_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [31:0] value, [63:32] modulus
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] inverse
    output logic [0:0]  m_tuser    // [0] not_invertible
);

    ctrl_t                    ctrl;
    status_t                  status;
    logic [OPERAND_WIDTH-1:0] inverse;
    logic                     not_invertible;

    // sequencer: owns the handshake and picks the datapath operation
    minv_fsm u_fsm (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .out_ready (m_tready),
        .status    (status),
        .ctrl      (ctrl),
        .in_ready  (s_tready),
        .out_valid (m_tvalid)
    );

    // datapath: remainders, coefficients, aligned divisor and the shared unit
    minv_dpath u_dpath (
        .aclk           (aclk),
        .ctrl           (ctrl),
        .value          (s_tdata[31:0]),
        .modulus        (s_tdata[63:32]),
        .status         (status),
        .inverse        (inverse),
        .not_invertible (not_invertible)
    );

    // result is held in datapath registers until the beat is taken
    assign m_tdata    = inverse;
    assign m_tuser[0] = not_invertible;

    // never accepting while a result is being offered
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input ready while result beat pending");

    // flagged result always carries a zero inverse
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata == '0))
        else $error("not_invertible with nonzero inverse");

    // an accepted beat starts work: no ready and no result on the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (!s_tready && !m_tvalid))
        else $error("sequencer did not start after accept");

endmodule
